// ===== src/slfr_pkg.sv =====
// Package for the sync/length frame receiver: parser phases, status and
// message class codes, known message IDs and the result record.
// Depends on nothing; used by every module of the receiver.
`timescale 1ns / 1ps

package slfr_pkg;

	// Parser phase within a frame.
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_ID      = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4
	} phase_t;

	// Frame status codes.
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Message class codes.
	localparam logic [1:0] CL_RESPONSE     = 2'd0;
	localparam logic [1:0] CL_CAPABILITIES = 2'd1;
	localparam logic [1:0] CL_BROADCAST    = 2'd2;
	localparam logic [1:0] CL_UNKNOWN      = 2'd3;

	// Known message IDs.
	localparam logic [7:0] ID_RESPONSE     = 8'h40;
	localparam logic [7:0] ID_CAPABILITIES = 8'h54;
	localparam logic [7:0] ID_BROADCAST    = 8'h4E;

	// Sync byte after reset.
	localparam logic [7:0] SYNC_RESET = 8'hA4;

	// One delivered frame result.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] message_id;
		logic [7:0] payload_length;
		logic [1:0] id_class;
		logic [7:0] last_payload_byte;
	} slfr_result_t;

	// Map a message ID onto its class.
	function automatic logic [1:0] classify(input logic [7:0] id);
		logic [1:0] cls;
		case (id)
			ID_RESPONSE:     cls = CL_RESPONSE;
			ID_CAPABILITIES: cls = CL_CAPABILITIES;
			ID_BROADCAST:    cls = CL_BROADCAST;
			default:         cls = CL_UNKNOWN;
		endcase
		return cls;
	endfunction

endpackage

// ===== src/slfr_parser.sv =====
// Frame parser state machine: tracks the phase, byte count, running XOR
// and captured bytes, and flags a result on the byte that ends a frame.
// Depends on slfr_pkg.
`timescale 1ns / 1ps

module slfr_parser
	import slfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_en,
	input  logic [7:0]   rx_byte,
	input  logic [7:0]   sync_byte,
	output logic         res_en,
	output slfr_result_t res
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	phase_t      phase_q, phase_d;
	logic [CW-1:0] count_q, count_d, count_inc;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  last_q, last_d;

	assign count_inc = count_q + 1'b1;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			xor_q   <= '0;
			len_q   <= '0;
			id_q    <= '0;
			last_q  <= '0;
		end else if (byte_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			xor_q   <= xor_d;
			len_q   <= len_d;
			id_q    <= id_d;
			last_q  <= last_d;
		end
	end

	// Next state and result for the current byte.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		xor_d   = xor_q;
		len_d   = len_q;
		id_d    = id_q;
		last_d  = last_q;
		res_en  = 1'b0;
		res     = '{ST_GOOD, id_q, len_q, classify(id_q), last_q};
		unique case (phase_q)
			PH_LENGTH: begin
				len_d = rx_byte;
				xor_d = xor_q ^ rx_byte;
				if (rx_byte > MAX_LEN) begin
					res_en  = 1'b1;
					res     = '{ST_TOO_LONG, 8'd0, rx_byte, CL_UNKNOWN, 8'd0};
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				id_d    = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				count_d = '0;
				phase_d = (len_q == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				xor_d   = xor_q ^ rx_byte;
				last_d  = rx_byte;
				count_d = count_inc;
				if (8'(count_inc) >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res_en     = 1'b1;
				res.status = (rx_byte == xor_q) ? ST_GOOD : ST_MISMATCH;
				phase_d    = PH_HUNT;
			end
			default: begin
				// Hunting: everything but the sync byte is dropped.
				phase_d = PH_HUNT;
				if (rx_byte == sync_byte) begin
					xor_d   = rx_byte;
					count_d = '0;
					len_d   = '0;
					id_d    = '0;
					last_d  = '0;
					phase_d = PH_LENGTH;
				end
			end
		endcase
	end

endmodule

// ===== src/sync_length_frame_receiver.sv =====
// Top level of the sync/length frame receiver: sync register, parser and
// output register. Depends on slfr_pkg and slfr_parser.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per
//   transaction. The parser hunts for the sync byte, then takes the length,
//   message ID, payload bytes and checksum byte of a frame.
//   Output channel (out_valid/out_ready) delivers one result per frame: on
//   the checksum byte, or at once on a length byte above MAX_PAYLOAD.
//   Config channel (cfg_valid/cfg_ready, sync_value) sets the sync byte and is
//   always ready; the user must write it only while the receiver is idle.
// Latency and throughput:
//   One byte per cycle unless a result waits on out_ready. A result appears
//   on the output register the cycle after the byte that ends the frame is
//   taken; each byte is handled by one pass through the parser logic.
// Reset:
//   The parser hunts for sync, the sync byte returns to 0xA4 and the output
//   register is empty.
// Stall:
//   While a result waits on out_ready, in_ready is low for every byte, since
//   the output register is full. In a cycle where out_ready is high the
//   waiting result is taken and a new byte is accepted at the same edge.

module sync_length_frame_receiver
	import slfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = 17
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] sync_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] message_id,
	output logic [7:0] payload_length,
	output logic [1:0] id_class,
	output logic [7:0] last_payload_byte
);

	logic [7:0]   sync_q;
	logic         byte_en;
	logic         res_en;
	slfr_result_t res;
	logic         out_valid_q;
	slfr_result_t out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign byte_en   = in_valid && in_ready;

	// Sync byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_q <= sync_value;
		end
	end

	slfr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_en  (byte_en),
		.rx_byte  (rx_byte),
		.sync_byte(sync_q),
		.res_en   (res_en),
		.res      (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (byte_en && res_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (byte_en && res_en) begin
			out_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_q.status;
	assign message_id        = out_q.message_id;
	assign payload_length    = out_q.payload_length;
	assign id_class          = out_q.id_class;
	assign last_payload_byte = out_q.last_payload_byte;

endmodule

// ===== src/slfr_checker.sv =====
// Port-level checks for the sync/length frame receiver, bound to the top
// level. Depends on slfr_pkg and sync_length_frame_receiver.
`timescale 1ns / 1ps

module slfr_checker
	import slfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = 17
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [7:0] message_id,
	input logic [7:0] payload_length,
	input logic [1:0] id_class,
	input logic [7:0] last_payload_byte
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(message_id) && $stable(payload_length))
		else $error("stalled result changed");

	// A new result follows an accepted input transaction.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without input transaction");

	// An over-length drop carries the fixed fields and a length over limit.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TOO_LONG |-> payload_length > MAX_LEN
			&& message_id == 8'd0 && id_class == CL_UNKNOWN
			&& last_payload_byte == 8'd0)
		else $error("bad over-length result");

	// Completed frames respect the length limit and the ID class.
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_GOOD || status == ST_MISMATCH)
			|-> payload_length <= MAX_LEN && id_class == classify(message_id))
		else $error("bad frame result");

endmodule

bind sync_length_frame_receiver slfr_checker #(
	.MAX_PAYLOAD(MAX_PAYLOAD)
) u_slfr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.message_id       (message_id),
	.payload_length   (payload_length),
	.id_class         (id_class),
	.last_payload_byte(last_payload_byte)
);
